// File: design/dtst_pkg.sv
// Deferred task slot table: shared types, constants and codes.
// Used by every module of the block but dtst_ram; depends on nothing.
`timescale 1ns / 1ps

package dtst_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int LINK_W     = SLOT_W + 1;
  localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(SLOT_COUNT);

  localparam int WAIT_W = 17;
  localparam int LIM_W  = 37;
  localparam logic [WAIT_W-1:0] WAIT_RESET = WAIT_W'(60);
  localparam logic [19:0] US_PER_S = 20'd1000000;

  typedef enum logic [2:0] {
    K_ADD         = 3'd0,
    K_REQUEUE     = 3'd1,
    K_TAKE_READY  = 3'd2,
    K_TAKE_OLDEST = 3'd3,
    K_RELEASE     = 3'd4,
    K_LOOKUP      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PL_UNUSED = 2'd0,
    PL_HELD   = 2'd1,
    PL_FREE   = 2'd2,
    PL_PEND   = 2'd3
  } place_e;

  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] obj;
    logic [63:0] version;
    logic [62:0] start;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_POP_RD,
    CMD_POP,
    CMD_ALLOC_HW,
    CMD_PLACE_RD,
    CMD_SET_CUR_HELD,
    CMD_SET_CUR_HEAD,
    CMD_SET_CUR_P,
    CMD_SRCH_INIT,
    CMD_SRCH_RD,
    CMD_SRCH_STEP,
    CMD_APPEND1,
    CMD_APPEND2,
    CMD_MERGE,
    CMD_PUSH_FREE,
    CMD_UNL_RD,
    CMD_UNLINK,
    CMD_FIN_FULL,
    CMD_FIN_NONE,
    CMD_FIN_REL,
    CMD_FIN_FOUND,
    CMD_FIN_ADD,
    CMD_FIN_MERGE,
    CMD_FIN_TAKE
  } cmd_e;

  typedef struct packed {
    kind_e kind;
    logic  free_nonempty;
    logic  hw_avail;
    logic  held_lt_hw;
    logic  place_held;
    logic  pend_nonempty;
    logic  walk_more;
    logic  hit;
  } stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_CHK,
    S_REL_PUSH,
    S_FIN_REL,
    S_SRCH_INIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_APPEND,
    S_APPEND2,
    S_FIN_ADD,
    S_MERGE,
    S_FIN_MERGE,
    S_UNL_RD,
    S_UNL_WR,
    S_FIN_TAKE
  } state_e;

endpackage

// File: design/dtst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
`timescale 1ns / 1ps

module dtst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/dtst_ctrl.sv
// Slot table sequencer: walks each operation through its datapath steps.
// Depends on dtst_pkg for states, commands and status.
`timescale 1ns / 1ps

module dtst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  dtst_pkg::stat_t stat_i,
  output dtst_pkg::cmd_e  cmd_o,
  output logic           busy
);
  import dtst_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.kind)
          K_ADD: begin
            if (stat_i.free_nonempty) state_d = S_POP;
            else if (stat_i.hw_avail) state_d = S_SRCH_INIT;
            else state_d = S_IDLE;
          end
          K_REQUEUE, K_RELEASE: state_d = stat_i.held_lt_hw ? S_CHK : S_IDLE;
          K_TAKE_READY, K_LOOKUP: state_d = S_SRCH_INIT;
          K_TAKE_OLDEST: state_d = stat_i.pend_nonempty ? S_UNL_RD : S_IDLE;
          default: state_d = S_IDLE;
        endcase
      end
      S_POP: state_d = S_SRCH_INIT;
      S_CHK: begin
        if (!stat_i.place_held) state_d = S_IDLE;
        else if (stat_i.kind == K_RELEASE) state_d = S_REL_PUSH;
        else state_d = S_SRCH_INIT;
      end
      S_REL_PUSH: state_d = S_FIN_REL;
      S_FIN_REL: state_d = S_IDLE;
      S_SRCH_INIT: state_d = S_SRCH_RD;
      S_SRCH_RD: begin
        if (stat_i.walk_more) state_d = S_SRCH_CMP;
        else if (stat_i.kind == K_ADD || stat_i.kind == K_REQUEUE) state_d = S_APPEND;
        else state_d = S_IDLE;
      end
      S_SRCH_CMP: begin
        if (!stat_i.hit) state_d = S_SRCH_RD;
        else if (stat_i.kind == K_LOOKUP) state_d = S_IDLE;
        else if (stat_i.kind == K_TAKE_READY) state_d = S_UNL_RD;
        else state_d = S_MERGE;
      end
      S_APPEND: state_d = stat_i.pend_nonempty ? S_APPEND2 : S_FIN_ADD;
      S_APPEND2: state_d = S_FIN_ADD;
      S_FIN_ADD: state_d = S_IDLE;
      S_MERGE: state_d = S_FIN_MERGE;
      S_FIN_MERGE: state_d = S_IDLE;
      S_UNL_RD: state_d = S_UNL_WR;
      S_UNL_WR: state_d = S_FIN_TAKE;
      S_FIN_TAKE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) cmd_o = CMD_LOAD;
      end
      S_DISPATCH: begin
        case (stat_i.kind)
          K_ADD: begin
            if (stat_i.free_nonempty) cmd_o = CMD_POP_RD;
            else if (stat_i.hw_avail) cmd_o = CMD_ALLOC_HW;
            else cmd_o = CMD_FIN_FULL;
          end
          K_REQUEUE, K_RELEASE: cmd_o = stat_i.held_lt_hw ? CMD_PLACE_RD : CMD_FIN_NONE;
          K_TAKE_READY, K_LOOKUP: cmd_o = CMD_NONE;
          K_TAKE_OLDEST: cmd_o = stat_i.pend_nonempty ? CMD_SET_CUR_HEAD : CMD_FIN_NONE;
          default: cmd_o = CMD_FIN_NONE;
        endcase
      end
      S_POP: cmd_o = CMD_POP;
      S_CHK: cmd_o = stat_i.place_held ? CMD_SET_CUR_HELD : CMD_FIN_NONE;
      S_REL_PUSH: cmd_o = CMD_PUSH_FREE;
      S_FIN_REL: cmd_o = CMD_FIN_REL;
      S_SRCH_INIT: cmd_o = CMD_SRCH_INIT;
      S_SRCH_RD: begin
        if (stat_i.walk_more) cmd_o = CMD_SRCH_RD;
        else if (stat_i.kind == K_ADD || stat_i.kind == K_REQUEUE) cmd_o = CMD_NONE;
        else cmd_o = CMD_FIN_NONE;
      end
      S_SRCH_CMP: begin
        if (!stat_i.hit) cmd_o = CMD_SRCH_STEP;
        else if (stat_i.kind == K_LOOKUP) cmd_o = CMD_FIN_FOUND;
        else if (stat_i.kind == K_TAKE_READY) cmd_o = CMD_SET_CUR_P;
        else cmd_o = CMD_NONE;
      end
      S_APPEND: cmd_o = CMD_APPEND1;
      S_APPEND2: cmd_o = CMD_APPEND2;
      S_FIN_ADD: cmd_o = CMD_FIN_ADD;
      S_MERGE: cmd_o = CMD_MERGE;
      S_FIN_MERGE: cmd_o = CMD_FIN_MERGE;
      S_UNL_RD: cmd_o = CMD_UNL_RD;
      S_UNL_WR: cmd_o = CMD_UNLINK;
      S_FIN_TAKE: cmd_o = CMD_FIN_TAKE;
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

// File: design/dtst_dp.sv
// Slot table datapath: list pointers, link/entry/place RAMs, compares, result.
// Depends on dtst_pkg and dtst_ram.
`timescale 1ns / 1ps

module dtst_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dtst_pkg::cmd_e             cmd_i,
  output dtst_pkg::stat_t            stat_o,
  input  logic                       cfg_valid_i,
  input  logic [dtst_pkg::WAIT_W-1:0] cfg_wait_limit_seconds_i,
  input  logic [2:0]                 kind_i,
  input  logic [31:0]                owner_key_i,
  input  logic [31:0]                object_key_i,
  input  logic [63:0]                ready_version_i,
  input  logic [62:0]                now_us_i,
  input  logic [63:0]                min_version_i,
  input  logic [9:0]                 held_slot_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [9:0]                 slot_o,
  output logic                       merged_o,
  output logic [31:0]                out_owner_key_o,
  output logic [31:0]                out_object_key_o,
  output logic [62:0]                out_start_us_o
);
  import dtst_pkg::*;

  logic [2:0]  kind_q;
  logic [31:0] owner_q, obj_q;
  logic [63:0] ver_q, minv_q;
  logic [62:0] now_q;
  logic [9:0]  held_q;

  logic [LINK_W-1:0] hw_q, free_head_q, free_tail_q, free_cnt_q;
  logic [LINK_W-1:0] pend_head_q, pend_tail_q, pend_cnt_q;
  logic [LINK_W-1:0] p_q, steps_q;
  logic [SLOT_W-1:0] cur_q;
  logic [WAIT_W-1:0] wait_q;
  logic [LIM_W-1:0]  limit_q;

  logic        done_q, merged_q;
  logic [1:0]  status_q;
  logic [9:0]  slot_q;
  logic [31:0] res_owner_q, res_obj_q;
  logic [62:0] res_start_q;

  logic              nx_we, nx_re, pv_we, pv_re, dt_we, dt_re, pl_we, pl_re;
  logic [SLOT_W-1:0] nx_waddr, nx_raddr, pv_waddr, pv_raddr;
  logic [SLOT_W-1:0] dt_waddr, dt_raddr, pl_waddr, pl_raddr;
  logic [LINK_W-1:0] nx_wdata, nx_rdata, pv_wdata, pv_rdata;
  entry_t            dt_wdata, dt_rdata, new_entry;
  logic [1:0]        pl_wdata, pl_rdata;
  logic [LINK_W-1:0] cur_link;
  logic [62:0]       age;
  logic              key_hit, ready_hit;
  logic [LINK_W-1:0] pend_cnt_dec;

  dtst_ram #(.Width(LINK_W), .Depth(SLOT_COUNT)) u_next_ram (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .re_i(nx_re), .raddr_i(nx_raddr), .rdata_o(nx_rdata)
  );
  dtst_ram #(.Width(LINK_W), .Depth(SLOT_COUNT)) u_prev_ram (
    .clk_i, .we_i(pv_we), .waddr_i(pv_waddr), .wdata_i(pv_wdata),
    .re_i(pv_re), .raddr_i(pv_raddr), .rdata_o(pv_rdata)
  );
  dtst_ram #(.Width($bits(entry_t)), .Depth(SLOT_COUNT)) u_entry_ram (
    .clk_i, .we_i(dt_we), .waddr_i(dt_waddr), .wdata_i(dt_wdata),
    .re_i(dt_re), .raddr_i(dt_raddr), .rdata_o(dt_rdata)
  );
  dtst_ram #(.Width(2), .Depth(SLOT_COUNT)) u_place_ram (
    .clk_i, .we_i(pl_we), .waddr_i(pl_waddr), .wdata_i(pl_wdata),
    .re_i(pl_re), .raddr_i(pl_raddr), .rdata_o(pl_rdata)
  );

  assign cur_link  = {1'b0, cur_q};
  assign new_entry = '{owner: owner_q, obj: obj_q, version: ver_q, start: now_q};
  assign age       = now_q - dt_rdata.start;
  assign key_hit   = (dt_rdata.owner == owner_q) && (dt_rdata.obj == obj_q);
  assign ready_hit = ((now_q >= dt_rdata.start) && (age > 63'(limit_q)))
                     || (minv_q >= dt_rdata.version);
  assign pend_cnt_dec = (pend_cnt_q != '0) ? pend_cnt_q - LINK_W'(1) : '0;

  always_comb begin
    stat_o.kind          = kind_e'(kind_q);
    stat_o.free_nonempty = (free_cnt_q != '0);
    stat_o.hw_avail      = (hw_q < NO_SLOT);
    stat_o.held_lt_hw    = ({1'b0, held_q} < hw_q);
    stat_o.place_held    = (pl_rdata == PL_HELD);
    stat_o.pend_nonempty = (pend_cnt_q != '0);
    stat_o.walk_more     = (steps_q < pend_cnt_q) && (p_q < NO_SLOT);
    stat_o.hit           = (kind_e'(kind_q) == K_TAKE_READY) ? ready_hit : key_hit;
  end

  // RAM ports
  always_comb begin
    nx_we = 1'b0; nx_re = 1'b0; nx_waddr = '0; nx_raddr = '0; nx_wdata = '0;
    pv_we = 1'b0; pv_re = 1'b0; pv_waddr = '0; pv_raddr = '0; pv_wdata = '0;
    dt_we = 1'b0; dt_re = 1'b0; dt_waddr = '0; dt_raddr = '0; dt_wdata = '0;
    pl_we = 1'b0; pl_re = 1'b0; pl_waddr = '0; pl_raddr = '0; pl_wdata = '0;
    case (cmd_i)
      CMD_POP_RD: begin
        nx_re    = 1'b1;
        nx_raddr = free_head_q[SLOT_W-1:0];
      end
      CMD_PLACE_RD: begin
        pl_re    = 1'b1;
        pl_raddr = held_q;
      end
      CMD_SRCH_RD: begin
        nx_re    = 1'b1;
        nx_raddr = p_q[SLOT_W-1:0];
        dt_re    = 1'b1;
        dt_raddr = p_q[SLOT_W-1:0];
      end
      CMD_APPEND1: begin
        dt_we    = 1'b1;
        dt_waddr = cur_q;
        dt_wdata = new_entry;
        nx_we    = 1'b1;
        nx_waddr = cur_q;
        nx_wdata = NO_SLOT;
        pv_we    = 1'b1;
        pv_waddr = cur_q;
        pv_wdata = (pend_cnt_q == '0) ? NO_SLOT : pend_tail_q;
        pl_we    = 1'b1;
        pl_waddr = cur_q;
        pl_wdata = PL_PEND;
      end
      CMD_APPEND2: begin
        nx_we    = 1'b1;
        nx_waddr = pend_tail_q[SLOT_W-1:0];
        nx_wdata = cur_link;
      end
      CMD_MERGE, CMD_PUSH_FREE: begin
        if (cmd_i == CMD_MERGE) begin
          dt_we    = 1'b1;
          dt_waddr = p_q[SLOT_W-1:0];
          dt_wdata = new_entry;
        end
        pl_we    = 1'b1;
        pl_waddr = cur_q;
        pl_wdata = PL_FREE;
        if (free_cnt_q != '0) begin
          nx_we    = 1'b1;
          nx_waddr = free_tail_q[SLOT_W-1:0];
          nx_wdata = cur_link;
        end
      end
      CMD_UNL_RD: begin
        nx_re    = 1'b1;
        nx_raddr = cur_q;
        pv_re    = 1'b1;
        pv_raddr = cur_q;
        dt_re    = 1'b1;
        dt_raddr = cur_q;
      end
      CMD_UNLINK: begin
        if (pv_rdata < NO_SLOT) begin
          nx_we    = 1'b1;
          nx_waddr = pv_rdata[SLOT_W-1:0];
          nx_wdata = nx_rdata;
        end
        if (nx_rdata < NO_SLOT) begin
          pv_we    = 1'b1;
          pv_waddr = nx_rdata[SLOT_W-1:0];
          pv_wdata = pv_rdata;
        end
        pl_we    = 1'b1;
        pl_waddr = cur_q;
        pl_wdata = PL_HELD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      kind_q  <= kind_i;
      owner_q <= owner_key_i;
      obj_q   <= object_key_i;
      ver_q   <= ready_version_i;
      now_q   <= now_us_i;
      minv_q  <= min_version_i;
      held_q  <= held_slot_i;
    end
    case (cmd_i)
      CMD_FIN_FULL, CMD_FIN_NONE: begin
        status_q    <= (cmd_i == CMD_FIN_FULL) ? ST_FULL : ST_NONE;
        slot_q      <= '0;
        merged_q    <= 1'b0;
        res_owner_q <= '0;
        res_obj_q   <= '0;
        res_start_q <= '0;
      end
      CMD_FIN_REL: begin
        status_q    <= ST_OK;
        slot_q      <= cur_q;
        merged_q    <= 1'b0;
        res_owner_q <= '0;
        res_obj_q   <= '0;
        res_start_q <= '0;
      end
      CMD_FIN_FOUND, CMD_FIN_TAKE: begin
        status_q    <= ST_OK;
        slot_q      <= (cmd_i == CMD_FIN_FOUND) ? p_q[SLOT_W-1:0] : cur_q;
        merged_q    <= 1'b0;
        res_owner_q <= dt_rdata.owner;
        res_obj_q   <= dt_rdata.obj;
        res_start_q <= dt_rdata.start;
      end
      CMD_FIN_ADD, CMD_FIN_MERGE: begin
        status_q    <= ST_OK;
        slot_q      <= (cmd_i == CMD_FIN_MERGE) ? p_q[SLOT_W-1:0] : cur_q;
        merged_q    <= (cmd_i == CMD_FIN_MERGE);
        res_owner_q <= owner_q;
        res_obj_q   <= obj_q;
        res_start_q <= now_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hw_q        <= '0;
      free_head_q <= NO_SLOT;
      free_tail_q <= NO_SLOT;
      free_cnt_q  <= '0;
      pend_head_q <= NO_SLOT;
      pend_tail_q <= NO_SLOT;
      pend_cnt_q  <= '0;
      p_q         <= NO_SLOT;
      steps_q     <= '0;
      cur_q       <= '0;
      wait_q      <= WAIT_RESET;
      limit_q     <= LIM_W'(WAIT_RESET * US_PER_S);
      done_q      <= 1'b0;
    end else begin
      done_q  <= (cmd_i == CMD_FIN_FULL) || (cmd_i == CMD_FIN_NONE) ||
                 (cmd_i == CMD_FIN_REL) || (cmd_i == CMD_FIN_FOUND) ||
                 (cmd_i == CMD_FIN_TAKE) || (cmd_i == CMD_FIN_ADD) ||
                 (cmd_i == CMD_FIN_MERGE);
      if (cfg_valid_i) wait_q <= cfg_wait_limit_seconds_i;
      limit_q <= LIM_W'(wait_q * US_PER_S);
      case (cmd_i)
        CMD_ALLOC_HW: begin
          cur_q <= hw_q[SLOT_W-1:0];
          hw_q  <= hw_q + LINK_W'(1);
        end
        CMD_POP: begin
          cur_q <= free_head_q[SLOT_W-1:0];
          if (free_cnt_q == LINK_W'(1) || nx_rdata >= NO_SLOT) begin
            free_head_q <= NO_SLOT;
            free_tail_q <= NO_SLOT;
            free_cnt_q  <= '0;
          end else begin
            free_head_q <= nx_rdata;
            free_cnt_q  <= free_cnt_q - LINK_W'(1);
          end
        end
        CMD_SET_CUR_HELD: cur_q <= held_q;
        CMD_SET_CUR_HEAD: cur_q <= pend_head_q[SLOT_W-1:0];
        CMD_SET_CUR_P:    cur_q <= p_q[SLOT_W-1:0];
        CMD_SRCH_INIT: begin
          p_q     <= pend_head_q;
          steps_q <= '0;
        end
        CMD_SRCH_STEP: begin
          p_q     <= nx_rdata;
          steps_q <= steps_q + LINK_W'(1);
        end
        CMD_APPEND1: begin
          if (pend_cnt_q == '0) begin
            pend_head_q <= cur_link;
            pend_tail_q <= cur_link;
            pend_cnt_q  <= LINK_W'(1);
          end
        end
        CMD_APPEND2: begin
          pend_tail_q <= cur_link;
          pend_cnt_q  <= pend_cnt_q + LINK_W'(1);
        end
        CMD_MERGE, CMD_PUSH_FREE: begin
          if (free_cnt_q == '0) free_head_q <= cur_link;
          free_tail_q <= cur_link;
          free_cnt_q  <= free_cnt_q + LINK_W'(1);
        end
        CMD_UNLINK: begin
          if (pend_cnt_dec == '0) begin
            pend_head_q <= NO_SLOT;
            pend_tail_q <= NO_SLOT;
          end else begin
            if (cur_link == pend_head_q) pend_head_q <= nx_rdata;
            if (cur_link == pend_tail_q) pend_tail_q <= pv_rdata;
          end
          pend_cnt_q <= pend_cnt_dec;
        end
        default: ;
      endcase
    end
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign slot_o           = slot_q;
  assign merged_o         = merged_q;
  assign out_owner_key_o  = res_owner_q;
  assign out_object_key_o = res_obj_q;
  assign out_start_us_o   = res_start_q;

endmodule

// File: design/deferred_task_slot_table_unit.sv
// Deferred task slot table, top level: sequencer plus datapath.
// Depends on dtst_pkg, dtst_ctrl, dtst_dp (and dtst_ram below it).
//
//   channel  | handshake                  | beat
//   ---------+----------------------------+----------------------------------
//   request  | start, busy                | kind_i .. held_slot_i
//   result   | done_o (one-cycle strobe)  | status_o .. out_start_us_o
//   config   | cfg_valid_i, cfg_ready_o   | cfg_wait_limit_seconds_i
//
// One request at a time, held from the accept cycle to the done cycle. A full
// add finishes at dispatch; take_oldest unlinks the head; release checks the
// slot and frees it; lookup and take_ready walk the pending list, and take_ready
// then unlinks the entry found; add and requeue walk it, then append or merge.
// Each step of the pending list waits on one registered read of the link and
// entry RAMs. Reset is immediate: slots beyond the high-water mark read as
// unused, so no clearing pass runs. Results cannot be stalled.
`timescale 1ns / 1ps

module deferred_task_slot_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [31:0] owner_key_i,
  input  logic [31:0] object_key_i,
  input  logic [63:0] ready_version_i,
  input  logic [62:0] now_us_i,
  input  logic [63:0] min_version_i,
  input  logic [9:0]  held_slot_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [9:0]  slot_o,
  output logic        merged_o,
  output logic [31:0] out_owner_key_o,
  output logic [31:0] out_object_key_o,
  output logic [62:0] out_start_us_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_wait_limit_seconds_i
);
  import dtst_pkg::*;

  cmd_e  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  dtst_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .stat_i(stat), .cmd_o(cmd), .busy
  );

  dtst_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_valid_i, .cfg_wait_limit_seconds_i,
    .kind_i, .owner_key_i, .object_key_i, .ready_version_i, .now_us_i,
    .min_version_i, .held_slot_i,
    .done_o, .status_o, .slot_o, .merged_o, .out_owner_key_o,
    .out_object_key_o, .out_start_us_o
  );

endmodule

// File: sim/tb.sv
// Self-checking testbench for deferred_task_slot_table_unit: directed and random
// commands with an in-bench slot table predictor. Depends on dtst_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import dtst_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] owner;
    logic [31:0] obj;
    logic [63:0] ver;
    logic [62:0] now;
    logic [63:0] minv;
    logic [9:0]  held;
  } cmd_t;

  typedef struct {
    status_e     status;
    logic [9:0]  slot;
    logic        merged;
    logic [31:0] owner;
    logic [31:0] obj;
    logic [62:0] start_us;
  } res_t;

  localparam int WDOG_LIMIT = 20000;

  logic        clk_i, rst_ni, start, busy, done_o, merged_o, cfg_valid_i, cfg_ready_o;
  logic [2:0]  kind_i;
  logic [31:0] owner_key_i, object_key_i, out_owner_key_o, out_object_key_o;
  logic [63:0] ready_version_i, min_version_i;
  logic [62:0] now_us_i, out_start_us_o;
  logic [9:0]  held_slot_i, slot_o;
  logic [1:0]  status_o;
  logic [16:0] cfg_wait_limit_seconds_i;

  deferred_task_slot_table_unit dut (.*);

  // table model
  int          nxt [SLOT_COUNT];
  int          prv [SLOT_COUNT];
  logic [31:0] e_owner [SLOT_COUNT];
  logic [31:0] e_obj [SLOT_COUNT];
  logic [63:0] e_ver [SLOT_COUNT];
  logic [62:0] e_start [SLOT_COUNT];
  place_e      place [SLOT_COUNT];
  int hwm, fhead, ftail, fcnt, phead, ptail, pcnt;
  logic [16:0] wait_lim;

  cmd_t cmd_q[$];
  res_t result_q[$];
  int   errors, idle_cycles, gap, gap_mode;
  bit   took;
  logic [62:0] clock_us;

  function automatic int alloc_slot();
    int s;
    if (fcnt > 0) begin
      s = fhead;
      fhead = nxt[s];
      fcnt--;
      if (fcnt == 0) begin
        fhead = SLOT_COUNT;
        ftail = SLOT_COUNT;
      end else prv[fhead] = SLOT_COUNT;
    end else if (hwm < SLOT_COUNT) begin
      s = hwm;
      hwm++;
    end else return -1;
    nxt[s] = SLOT_COUNT;
    prv[s] = SLOT_COUNT;
    place[s] = PL_HELD;
    return s;
  endfunction

  function automatic void free_slot(int s);
    nxt[s] = SLOT_COUNT;
    prv[s] = SLOT_COUNT;
    if (fcnt == 0) fhead = s;
    else begin
      nxt[ftail] = s;
      prv[s] = ftail;
    end
    ftail = s;
    fcnt++;
    place[s] = PL_FREE;
  endfunction

  function automatic void unlink_slot(int s);
    int p, n;
    p = prv[s];
    n = nxt[s];
    if (p < SLOT_COUNT) nxt[p] = n;
    if (n < SLOT_COUNT) prv[n] = p;
    if (s == phead) phead = n;
    if (s == ptail) ptail = p;
    pcnt--;
    if (pcnt == 0) begin
      phead = SLOT_COUNT;
      ptail = SLOT_COUNT;
    end
    nxt[s] = SLOT_COUNT;
    prv[s] = SLOT_COUNT;
    place[s] = PL_HELD;
  endfunction

  function automatic int find_key(logic [31:0] o, logic [31:0] b);
    for (int p = phead; p < SLOT_COUNT; p = nxt[p])
      if (e_owner[p] == o && e_obj[p] == b) return p;
    return SLOT_COUNT;
  endfunction

  function automatic int find_ready(logic [62:0] now, logic [63:0] minv);
    logic [63:0] lim;
    lim = 64'(wait_lim) * 64'd1000000;
    for (int p = phead; p < SLOT_COUNT; p = nxt[p]) begin
      if (now >= e_start[p] && 64'(now - e_start[p]) > lim) return p;
      if (minv >= e_ver[p]) return p;
    end
    return SLOT_COUNT;
  endfunction

  function automatic res_t entry_res(int s);
    res_t r;
    r = '{ST_OK, s[9:0], 1'b0, e_owner[s], e_obj[s], e_start[s]};
    return r;
  endfunction

  function automatic res_t place_work(int s, cmd_t c);
    int m, t;
    res_t r;
    m = find_key(c.owner, c.obj);
    t = (m < SLOT_COUNT) ? m : s;
    e_owner[t] = c.owner;
    e_obj[t] = c.obj;
    e_ver[t] = c.ver;
    e_start[t] = c.now;
    if (m < SLOT_COUNT) free_slot(s);
    else begin
      nxt[s] = SLOT_COUNT;
      prv[s] = SLOT_COUNT;
      if (pcnt == 0) phead = s;
      else begin
        nxt[ptail] = s;
        prv[s] = ptail;
      end
      ptail = s;
      pcnt++;
      place[s] = PL_PEND;
    end
    r = entry_res(t);
    r.merged = (m < SLOT_COUNT);
    return r;
  endfunction

  function automatic res_t predict_table(cmd_t c);
    res_t r;
    int s;
    r = '{ST_NONE, '0, 1'b0, '0, '0, '0};
    case (c.kind)
      K_ADD: begin
        s = alloc_slot();
        if (s < 0) r.status = ST_FULL;
        else r = place_work(s, c);
      end
      K_REQUEUE: if (place[c.held] == PL_HELD) r = place_work(c.held, c);
      K_TAKE_READY, K_TAKE_OLDEST: begin
        s = (c.kind == K_TAKE_READY) ? find_ready(c.now, c.minv) : phead;
        if (s < SLOT_COUNT) begin
          unlink_slot(s);
          r = entry_res(s);
        end
      end
      K_RELEASE: if (place[c.held] == PL_HELD) begin
        free_slot(c.held);
        r.status = ST_OK;
        r.slot = c.held;
      end
      K_LOOKUP: begin
        s = find_key(c.owner, c.obj);
        if (s < SLOT_COUNT) r = entry_res(s);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic issue(logic [2:0] k, logic [31:0] o, logic [31:0] b, logic [63:0] v,
                       logic [62:0] n, logic [63:0] mv, logic [9:0] h);
    cmd_t c;
    c = '{k, o, b, v, n, mv, h};
    result_q.push_back(predict_table(c));
    cmd_q.push_back(c);
  endtask

  function automatic logic [9:0] pick_held();
    int s;
    for (int i = 0; i < 8; i++) begin
      s = $urandom_range(0, (hwm > 0) ? hwm - 1 : 0);
      if (place[s] == PL_HELD) return s[9:0];
    end
    return 10'($urandom);
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return 32'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [63:0] pick_ver();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'($urandom_range(100, 300));
    endcase
  endfunction

  task automatic random_cmd(int take_bias);
    int r;
    logic [62:0] n;
    r = $urandom_range(0, 99);
    clock_us = clock_us + 63'($urandom_range(0, 40000000));
    n = ($urandom_range(0, 15) == 0) ? 63'({$urandom, $urandom}) :
        ($urandom_range(0, 7) == 0) ? clock_us - 63'($urandom_range(1, 5000000)) : clock_us;
    if (pcnt > 24) r = (r < 50) ? 30 : r;
    if (r < 30 - take_bias)
      issue(K_ADD, pick_key(), pick_key(), pick_ver(), n, '0, 10'($urandom));
    else if (r < 40) issue(K_REQUEUE, pick_key(), pick_key(), pick_ver(), n, '0, pick_held());
    else if (r < 58)
      issue(K_TAKE_READY, $urandom, $urandom, '0, n, pick_ver(), 10'($urandom));
    else if (r < 68) issue(K_TAKE_OLDEST, $urandom, $urandom, '0, n, '0, 10'($urandom));
    else if (r < 85) issue(K_RELEASE, $urandom, $urandom, '0, n, '0, pick_held());
    else if (r < 97) issue(K_LOOKUP, pick_key(), pick_key(), '0, n, '0, 10'($urandom));
    else issue(3'($urandom_range(6, 7)), $urandom, $urandom, '1, n, '1, 10'($urandom));
  endtask

  task automatic drain();
    wait (cmd_q.size() == 0 && !start && result_q.size() == 0);
  endtask

  task automatic set_wait_limit(logic [16:0] v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wait_limit_seconds_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    wait_lim = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    if (gap_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    cmd_t c;
    logic nxt_start;
    nxt_start = start;
    if (took) begin
      took = 1'b0;
      nxt_start = 1'b0;
      gap = pick_gap();
    end
    if (rst_ni && !nxt_start) begin
      if (gap > 0) gap--;
      else if (cmd_q.size() > 0) begin
        c = cmd_q.pop_front();
        kind_i <= c.kind;
        owner_key_i <= c.owner;
        object_key_i <= c.obj;
        ready_version_i <= c.ver;
        now_us_i <= c.now;
        min_version_i <= c.minv;
        held_slot_i <= c.held;
        nxt_start = 1'b1;
      end
    end
    start <= nxt_start;
  end

  // result monitor and watchdog
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      idle_cycles++;
      if (start && !busy) begin
        took = 1'b1;
        idle_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) idle_cycles = 0;
      if (done_o) begin
        idle_cycles = 0;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected: slot %0d", slot_o);
          errors++;
        end else begin
          e = result_q.pop_front();
          if (status_o !== e.status) begin
            $error("status exp %0d got %0d", e.status, status_o); errors++;
          end
          if (slot_o !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, slot_o); errors++;
          end
          if (merged_o !== e.merged) begin
            $error("merged exp %0d got %0d", e.merged, merged_o); errors++;
          end
          if (out_owner_key_o !== e.owner) begin
            $error("out_owner_key exp %h got %h", e.owner, out_owner_key_o); errors++;
          end
          if (out_object_key_o !== e.obj) begin
            $error("out_object_key exp %h got %h", e.obj, out_object_key_o); errors++;
          end
          if (out_start_us_o !== e.start_us) begin
            $error("out_start_us exp %h got %h", e.start_us, out_start_us_o); errors++;
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [16:0] limits[4];
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_wait_limit_seconds_i = '0;
    kind_i = '0; owner_key_i = '0; object_key_i = '0; ready_version_i = '0;
    now_us_i = '0; min_version_i = '0; held_slot_i = '0;
    errors = 0; idle_cycles = 0; gap = 0; gap_mode = 1; took = 1'b0;
    clock_us = 63'd1000;
    hwm = 0; fcnt = 0; pcnt = 0; wait_lim = WAIT_RESET;
    fhead = SLOT_COUNT; ftail = SLOT_COUNT; phead = SLOT_COUNT; ptail = SLOT_COUNT;
    foreach (place[i]) place[i] = PL_UNUSED;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, merge, lookups, takes, refusals, clock behind start
    issue(K_TAKE_OLDEST, '0, '0, '0, '0, '0, '0);
    issue(K_TAKE_READY, '0, '0, '0, '1, '1, '0);
    issue(K_ADD, '1, '1, '1, '1, '0, '1);
    issue(K_ADD, '0, '0, '0, '0, '0, '0);
    issue(K_ADD, '1, '1, 64'd5, 63'd500, '0, '0);
    issue(K_LOOKUP, '1, '1, '0, '0, '0, '0);
    issue(K_LOOKUP, 32'h1, '1, '0, '0, '0, '0);
    issue(K_TAKE_READY, '0, '0, '0, 63'd100, 64'd4, '0);
    issue(K_TAKE_READY, '0, '0, '0, 63'd100, 64'd5, '0);
    issue(K_RELEASE, '0, '0, '0, '0, '0, 10'd2);
    issue(K_RELEASE, '0, '0, '0, '0, '0, 10'd0);
    issue(K_RELEASE, '0, '0, '0, '0, '0, 10'd2);
    issue(K_REQUEUE, '0, '0, '0, '0, '0, 10'd2);
    issue(K_REQUEUE, '0, '0, '0, '0, '0, '1);
    issue(K_ADD, 32'h5, 32'h6, '1, 63'd60000001, '0, '0);
    issue(K_TAKE_OLDEST, '0, '0, '0, '0, '0, '0);
    issue(K_REQUEUE, 32'h5, 32'h6, '1, 63'd60000001, '0, 10'd0);
    issue(K_TAKE_READY, '0, '0, '0, 63'd0, '0, '0);
    issue(K_TAKE_READY, '0, '0, '0, 63'd120000002, '0, '0);
    issue(3'd6, '1, '1, '1, '1, '1, '1);
    issue(3'd7, '0, '0, '0, '0, '0, '0);
    issue(K_TAKE_OLDEST, '0, '0, '0, '0, '0, '0);

    limits = '{17'd0, 17'd86400, 17'd1, 17'd30};
    foreach (limits[p]) begin
      set_wait_limit(limits[p]);
      gap_mode = p % 2;
      for (int i = 0; i < 110; i++) random_cmd(0);
    end

    set_wait_limit(17'($urandom_range(0, 86400)));
    gap_mode = 1;
    for (int i = 0; i < 60; i++) random_cmd(25);

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/dtst_pkg.sv
design/dtst_ram.sv
design/dtst_ctrl.sv
design/dtst_dp.sv
design/deferred_task_slot_table_unit.sv
sim/tb.sv
